[hdl/psa_pkg.sv]
`default_nettype none

package psa_pkg;

  localparam int MAX_ENTRIES_DEFAULT = 256;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [63:0] MIN_START = 64'd1000000000;

  localparam logic [0:0] REG_WINDOW_START = 1'b0;
  localparam logic [0:0] REG_WINDOW_END   = 1'b1;

  typedef enum logic [2:0] {
    FN_ADD    = 3'd0,
    FN_CLEAR  = 3'd1,
    FN_SAMPLE = 3'd2,
    FN_READ   = 3'd3,
    FN_GROUP  = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_WINDOW    = 3'd2,
    ST_UNTRACKED = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    SEL_NONE    = 3'd0,
    SEL_RANGE   = 3'd1,
    SEL_ADDED   = 3'd2,
    SEL_CLEARED = 3'd3,
    SEL_GROUP   = 3'd4,
    SEL_READ    = 3'd5,
    SEL_UPDATED = 3'd6
  } res_sel_t;

  typedef struct packed {
    logic [31:0] count;
    logic [63:0] sum;
    logic [63:0] sq;
    logic [63:0] vmin;
    logic [63:0] vmax;
  } stat_t;

  localparam stat_t STAT_CLEARED = '{
    count: 32'd0,
    sum:   64'd0,
    sq:    64'd0,
    vmin:  MIN_START,
    vmax:  64'd0
  };

  typedef struct packed {
    logic     capture;
    logic     add_entry;
    logic     clear_group;
    logic     walk_clear;
    logic     scan_step;
    logic     sweep_step;
    logic     read_entry;
    logic     fetch_match;
    logic     update;
    logic     res_load;
    res_sel_t res_sel;
    status_t  res_status;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  table_full;
    logic  in_window;
    logic  ridx_oob;
    logic  walk_more;
    logic  cmp_pending;
    logic  cmp_hit;
    logic  sweep_last;
    logic  count_zero;
    logic  out_busy;
  } sts_t;

endpackage

`default_nettype wire

[hdl/per_key_stats_accumulator.sv]
`default_nettype none

// Channel   Direction  Handshake            Payload
// config    in         psel/penable/pready  paddr, pwdata, prdata (window_start, window_end)
// in        in         in_valid/in_stall    func, comp_id, timestamp_sec, sample_value,
//                                           read_index
// out       out        out_valid/out_stall  status, entry_index, has_data, record_count,
//                                           value_sum, square_sum, value_min, value_max
//
// Add, group read and unknown operations go from decode straight to done; an in-range entry
// read passes through a read state. A sample scans the id table, one table entry per cycle,
// until it meets the matching entry; an untracked id is scanned past all id_count entries.
// A clear sweeps a non-empty table to rewrite the entry statistics.
// Reset empties the table and restores the group figures; no memory pass is needed.
// in_stall stays high from acceptance until the result enters the output register, which
// holds its transaction while out_stall is high.

module per_key_stats_accumulator #(
  parameter int MAX_ENTRIES = psa_pkg::MAX_ENTRIES_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [psa_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [psa_pkg::PDATA_W-1:0]  pwdata,
  output logic      [psa_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [2:0]                   func,
  input  wire logic [31:0]                  comp_id,
  input  wire logic [31:0]                  timestamp_sec,
  input  wire logic [63:0]                  sample_value,
  input  wire logic [7:0]                   read_index,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [2:0]                   status,
  output logic      [7:0]                   entry_index,
  output logic                              has_data,
  output logic      [31:0]                  record_count,
  output logic      [63:0]                  value_sum,
  output logic      [63:0]                  square_sum,
  output logic      [63:0]                  value_min,
  output logic      [63:0]                  value_max
);

  logic [31:0]   window_start;
  logic [31:0]   window_end;
  psa_pkg::cmd_t cmd;
  psa_pkg::sts_t sts;

  psa_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .window_start (window_start),
    .window_end   (window_end)
  );

  psa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  psa_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .window_start  (window_start),
    .window_end    (window_end),
    .func          (func),
    .comp_id       (comp_id),
    .timestamp_sec (timestamp_sec),
    .sample_value  (sample_value),
    .read_index    (read_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .entry_index   (entry_index),
    .has_data      (has_data),
    .record_count  (record_count),
    .value_sum     (value_sum),
    .square_sum    (square_sum),
    .value_min     (value_min),
    .value_max     (value_max)
  );

endmodule

`default_nettype wire

[hdl/psa_ram.sv]
`default_nettype none

module psa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/psa_regs.sv]
`default_nettype none

module psa_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [psa_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [psa_pkg::PDATA_W-1:0]  pwdata,
  output logic      [psa_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  output logic      [31:0]                  window_start,
  output logic      [31:0]                  window_end
);

  logic       wr_en;
  logic [0:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= 32'd0;
      window_end   <= 32'hFFFF_FFFF;
    end else if (wr_en) begin
      case (reg_idx)
        psa_pkg::REG_WINDOW_START: window_start <= pwdata;
        psa_pkg::REG_WINDOW_END:   window_end   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      psa_pkg::REG_WINDOW_START: prdata = window_start;
      psa_pkg::REG_WINDOW_END:   prdata = window_end;
      default:                   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[hdl/psa_ctrl.sv]
`default_nettype none

module psa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire psa_pkg::sts_t sts,
  output psa_pkg::cmd_t      cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_SCAN   = 7'b0000100,
    S_UPDATE = 7'b0001000,
    S_READ   = 7'b0010000,
    S_SWEEP  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.res_sel    = psa_pkg::SEL_NONE;
    cmd.res_status = psa_pkg::ST_OK;
    state_next     = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_DONE;
        case (sts.func)
          psa_pkg::FN_ADD: begin
            cmd.res_load = 1'b1;
            if (sts.table_full) begin
              cmd.res_status = psa_pkg::ST_FULL;
            end else begin
              cmd.add_entry = 1'b1;
              cmd.res_sel   = psa_pkg::SEL_ADDED;
            end
          end
          psa_pkg::FN_CLEAR: begin
            cmd.clear_group = 1'b1;
            cmd.walk_clear  = 1'b1;
            cmd.res_load    = 1'b1;
            cmd.res_sel     = psa_pkg::SEL_CLEARED;
            if (!sts.count_zero) begin
              state_next = S_SWEEP;
            end
          end
          psa_pkg::FN_SAMPLE: begin
            if (sts.in_window) begin
              cmd.walk_clear = 1'b1;
              state_next     = S_SCAN;
            end else begin
              cmd.res_load   = 1'b1;
              cmd.res_status = psa_pkg::ST_WINDOW;
            end
          end
          psa_pkg::FN_READ: begin
            if (sts.ridx_oob) begin
              cmd.res_load   = 1'b1;
              cmd.res_sel    = psa_pkg::SEL_RANGE;
              cmd.res_status = psa_pkg::ST_RANGE;
            end else begin
              cmd.read_entry = 1'b1;
              state_next     = S_READ;
            end
          end
          psa_pkg::FN_GROUP: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = psa_pkg::SEL_GROUP;
          end
          default: begin
            cmd.res_load = 1'b1;
          end
        endcase
      end
      S_SCAN: begin
        if (sts.cmp_hit) begin
          cmd.fetch_match = 1'b1;
          state_next      = S_UPDATE;
        end else if (sts.walk_more || sts.cmp_pending) begin
          cmd.scan_step = 1'b1;
        end else begin
          cmd.res_load   = 1'b1;
          cmd.res_status = psa_pkg::ST_UNTRACKED;
          state_next     = S_DONE;
        end
      end
      S_UPDATE: begin
        cmd.update   = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_sel  = psa_pkg::SEL_UPDATED;
        state_next   = S_DONE;
      end
      S_READ: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = psa_pkg::SEL_READ;
        state_next   = S_DONE;
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/psa_datapath.sv]
`default_nettype none

module psa_datapath #(
  parameter int MAX_ENTRIES = psa_pkg::MAX_ENTRIES_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire psa_pkg::cmd_t cmd,
  output psa_pkg::sts_t      sts,
  input  wire logic [31:0]   window_start,
  input  wire logic [31:0]   window_end,
  input  wire logic [2:0]    func,
  input  wire logic [31:0]   comp_id,
  input  wire logic [31:0]   timestamp_sec,
  input  wire logic [63:0]   sample_value,
  input  wire logic [7:0]    read_index,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [2:0]         status,
  output logic [7:0]         entry_index,
  output logic               has_data,
  output logic [31:0]        record_count,
  output logic [63:0]        value_sum,
  output logic [63:0]        square_sum,
  output logic [63:0]        value_min,
  output logic [63:0]        value_max
);

  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > 8) ? CNT_W : 8;
  localparam int STAT_W = $bits(psa_pkg::stat_t);

  function automatic psa_pkg::stat_t accumulate(psa_pkg::stat_t s, logic [63:0] v,
                                                logic [63:0] sq);
    psa_pkg::stat_t r;
    r = s;
    if (s.count != 32'hFFFF_FFFF) begin
      r.count = s.count + 32'd1;
    end
    r.sum = s.sum + v;
    r.sq  = s.sq + sq;
    if (v < s.vmin) begin
      r.vmin = v;
    end
    if (v > s.vmax) begin
      r.vmax = v;
    end
    return r;
  endfunction

  logic [2:0]  func_r;
  logic [31:0] id_r;
  logic [31:0] ts_r;
  logic [63:0] v_r;
  logic [7:0]  ridx_r;

  logic [63:0] prod_lo;
  logic [31:0] prod_cross;
  logic [63:0] sq_r;

  logic [CNT_W-1:0] id_count;
  logic [CNT_W-1:0] walk_idx;
  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_idx;
  logic [IDX_W-1:0] match_idx;

  logic [31:0]       id_rdata;
  logic [STAT_W-1:0] stat_rdata;
  psa_pkg::stat_t    stat_rd;
  psa_pkg::stat_t    entry_new;
  psa_pkg::stat_t    group;

  logic              stat_we;
  logic [IDX_W-1:0]  stat_waddr;
  psa_pkg::stat_t    stat_wdata;
  logic [IDX_W-1:0]  stat_raddr;

  logic [CMP_W-1:0]   ridx_ext;
  logic [CMP_W-1:0]   cnt_ext;
  logic [CNT_W+7:0]   cnt_wide;
  logic [IDX_W+7:0]   match_wide;

  psa_pkg::status_t res_status;
  logic [7:0]       res_idx;
  psa_pkg::stat_t   res_stat;

  assign ridx_ext   = CMP_W'(ridx_r);
  assign cnt_ext    = CMP_W'(id_count);
  assign cnt_wide   = {8'd0, id_count};
  assign match_wide = {8'd0, match_idx};
  assign stat_rd    = psa_pkg::stat_t'(stat_rdata);
  assign entry_new  = accumulate(stat_rd, v_r, sq_r);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= func;
      id_r   <= comp_id;
      ts_r   <= timestamp_sec;
      v_r    <= sample_value;
      ridx_r <= read_index;
    end
  end

  // The low 64 bits of v*v need only the low-half square and the low bits of
  // the cross product, so two 32-bit multipliers feed one add stage.
  always_ff @(posedge clk) begin
    prod_lo    <= v_r[31:0] * v_r[31:0];
    prod_cross <= v_r[31:0] * v_r[63:32];
    sq_r       <= prod_lo + {prod_cross[30:0], 33'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id_count  <= '0;
      walk_idx  <= '0;
      cmp_valid <= 1'b0;
    end else begin
      if (cmd.add_entry) begin
        id_count <= id_count + CNT_W'(1);
      end
      if (cmd.walk_clear) begin
        walk_idx  <= '0;
        cmp_valid <= 1'b0;
      end else if (cmd.scan_step) begin
        cmp_valid <= sts.walk_more;
        if (sts.walk_more) begin
          walk_idx <= walk_idx + CNT_W'(1);
        end
      end else if (cmd.sweep_step) begin
        walk_idx <= walk_idx + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      cmp_idx <= walk_idx[IDX_W-1:0];
    end
    if (cmd.fetch_match) begin
      match_idx <= cmp_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_group) begin
      group <= psa_pkg::STAT_CLEARED;
    end else if (cmd.update) begin
      group <= accumulate(group, v_r, sq_r);
    end
  end

  psa_ram #(
    .WIDTH (32),
    .DEPTH (MAX_ENTRIES)
  ) u_id_ram (
    .clk   (clk),
    .we    (cmd.add_entry),
    .waddr (id_count[IDX_W-1:0]),
    .wdata (id_r),
    .re    (cmd.scan_step && sts.walk_more),
    .raddr (walk_idx[IDX_W-1:0]),
    .rdata (id_rdata)
  );

  always_comb begin
    stat_we    = cmd.add_entry || cmd.sweep_step || cmd.update;
    stat_wdata = psa_pkg::STAT_CLEARED;
    if (cmd.update) begin
      stat_waddr = match_idx;
      stat_wdata = entry_new;
    end else if (cmd.sweep_step) begin
      stat_waddr = walk_idx[IDX_W-1:0];
    end else begin
      stat_waddr = id_count[IDX_W-1:0];
    end
    stat_raddr = cmd.fetch_match ? cmp_idx : ridx_ext[IDX_W-1:0];
  end

  psa_ram #(
    .WIDTH (STAT_W),
    .DEPTH (MAX_ENTRIES)
  ) u_stat_ram (
    .clk   (clk),
    .we    (stat_we),
    .waddr (stat_waddr),
    .wdata (stat_wdata),
    .re    (cmd.read_entry || cmd.fetch_match),
    .raddr (stat_raddr),
    .rdata (stat_rdata)
  );

  always_comb begin
    sts.func        = psa_pkg::func_t'(func_r);
    sts.table_full  = (id_count == CNT_W'(MAX_ENTRIES));
    sts.in_window   = (ts_r >= window_start) && (ts_r <= window_end);
    sts.ridx_oob    = (ridx_ext >= cnt_ext);
    sts.walk_more   = (walk_idx < id_count);
    sts.cmp_pending = cmp_valid;
    sts.cmp_hit     = cmp_valid && (id_rdata == id_r);
    sts.sweep_last  = (walk_idx == id_count - CNT_W'(1));
    sts.count_zero  = (id_count == '0);
    sts.out_busy    = out_valid && out_stall;
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      case (cmd.res_sel)
        psa_pkg::SEL_RANGE: begin
          res_idx  <= ridx_r;
          res_stat <= '0;
        end
        psa_pkg::SEL_ADDED: begin
          res_idx  <= cnt_wide[7:0];
          res_stat <= psa_pkg::STAT_CLEARED;
        end
        psa_pkg::SEL_CLEARED: begin
          res_idx  <= 8'd0;
          res_stat <= psa_pkg::STAT_CLEARED;
        end
        psa_pkg::SEL_GROUP: begin
          res_idx  <= 8'd0;
          res_stat <= group;
        end
        psa_pkg::SEL_READ: begin
          res_idx  <= ridx_r;
          res_stat <= stat_rd;
        end
        psa_pkg::SEL_UPDATED: begin
          res_idx  <= match_wide[7:0];
          res_stat <= entry_new;
        end
        default: begin
          res_idx  <= 8'd0;
          res_stat <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status       <= res_status;
      entry_index  <= res_idx;
      has_data     <= (res_stat.count != 32'd0);
      record_count <= res_stat.count;
      value_sum    <= res_stat.sum;
      square_sum   <= res_stat.sq;
      value_min    <= res_stat.vmin;
      value_max    <= res_stat.vmax;
    end
  end

endmodule

`default_nettype wire
